// ===== hdl/axis_range_calibrate_normalize_unit_assert.svh =====
// Assertion helpers for the RTL.
`ifndef AXIS_RANGE_CALIBRATE_NORMALIZE_UNIT_ASSERT_SVH
`define AXIS_RANGE_CALIBRATE_NORMALIZE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define ARCN_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ARCN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/arcn_pkg.sv =====
package arcn_pkg;

   localparam int NUM_AXES_DEF      = 8;
   localparam int FRACTION_BITS_DEF = 14;
   localparam int RESULT_CAP        = 8;
   localparam int RAW_W             = 16;
   localparam int ALU_W             = 18;

   localparam logic signed [RAW_W-1:0] RAW_POS = 16'sd32767;
   localparam logic signed [RAW_W-1:0] RAW_NEG = -16'sd32767;

   // command codes
   localparam logic [2:0] CMD_EVENT  = 3'd0;
   localparam logic [2:0] CMD_SAMPLE = 3'd1;
   localparam logic [2:0] CMD_BEGIN  = 3'd2;
   localparam logic [2:0] CMD_FINISH = 3'd3;
   localparam logic [2:0] CMD_LOAD   = 3'd4;

   localparam int AXIS_EVENT_BIT = 1;

   // axis store write ops
   localparam logic [1:0] ST_NONE   = 2'd0;
   localparam logic [1:0] ST_SAMPLE = 2'd1;
   localparam logic [1:0] ST_CLEAR  = 2'd2;
   localparam logic [1:0] ST_BOUNDS = 2'd3;

   // shared subtractor ops
   localparam logic [1:0] ALU_CMP  = 2'd0;
   localparam logic [1:0] ALU_STEP = 2'd1;
   localparam logic [1:0] ALU_REST = 2'd2;

   typedef logic signed [RAW_W-1:0] raw_type;
   typedef logic signed [ALU_W-1:0] alu_word_type;

   typedef struct packed {
      logic [1:0] op;
      raw_type    lo;
      raw_type    hi;
      raw_type    sample;
   } store_wr_type;

   typedef struct packed {
      raw_type lo;
      raw_type hi;
      raw_type seen_min;
      raw_type seen_max;
      raw_type latest;
   } axis_rec_type;

   typedef struct packed {
      alu_word_type diff;
      logic         ge;
   } alu_res_type;

   function automatic alu_word_type sx_raw(input raw_type v);
      return {{(ALU_W-RAW_W){v[RAW_W-1]}}, v};
   endfunction

endpackage

// ===== hdl/arcn_axis_store.sv =====
module arcn_axis_store
   import arcn_pkg::*;
#(
   parameter int NUM_AXES = NUM_AXES_DEF,
   parameter int AXW      = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [AXW-1:0] idx,
   input  store_wr_type wr,
   output axis_rec_type rd
);

   raw_type lo_ff   [NUM_AXES];
   raw_type hi_ff   [NUM_AXES];
   raw_type smin_ff [NUM_AXES];
   raw_type smax_ff [NUM_AXES];
   raw_type rest_ff [NUM_AXES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            lo_ff[i]   <= RAW_NEG;
            hi_ff[i]   <= RAW_POS;
            smin_ff[i] <= RAW_POS;
            smax_ff[i] <= RAW_NEG;
            rest_ff[i] <= '0;
         end
      end else begin
         unique case (wr.op)
            ST_SAMPLE: begin
               rest_ff[idx] <= wr.sample;
               if ($signed(wr.sample) < $signed(smin_ff[idx])) smin_ff[idx] <= wr.sample;
               if ($signed(wr.sample) > $signed(smax_ff[idx])) smax_ff[idx] <= wr.sample;
            end
            ST_CLEAR: begin
               for (int i = 0; i < NUM_AXES; i++) begin
                  smin_ff[i] <= RAW_POS;
                  smax_ff[i] <= RAW_NEG;
                  rest_ff[i] <= '0;
               end
            end
            ST_BOUNDS: begin
               lo_ff[idx] <= wr.lo;
               hi_ff[idx] <= wr.hi;
            end
            default: ;
         endcase
      end
   end

   assign rd.lo       = lo_ff[idx];
   assign rd.hi       = hi_ff[idx];
   assign rd.seen_min = smin_ff[idx];
   assign rd.seen_max = smax_ff[idx];
   assign rd.latest   = rest_ff[idx];

endmodule

// ===== hdl/arcn_alu.sv =====
module arcn_alu
   import arcn_pkg::*;
(
   input  logic [1:0]   op,
   input  alu_word_type rem,
   input  alu_word_type div,
   input  raw_type      mn,
   input  raw_type      mx,
   input  raw_type      rest,
   output alu_res_type  res
);

   alu_word_type a;
   alu_word_type b;
   alu_word_type d;

   always_comb begin
      unique case (op)
         ALU_CMP: begin
            a = rem;
            b = div;
         end
         ALU_STEP: begin
            // restoring division step: doubled remainder against divisor
            a = {rem[ALU_W-2:0], 1'b0};
            b = div;
         end
         ALU_REST: begin
            // rest at or nearer the minimum iff mn + mx >= 2 * rest
            a = sx_raw(mn) + sx_raw(mx);
            b = {rest[RAW_W-1], rest, 1'b0};
         end
         default: begin
            a = '0;
            b = '0;
         end
      endcase
      d = a - b;
   end

   assign res.diff = d;
   assign res.ge   = ~d[ALU_W-1];

endmodule

// ===== hdl/axis_range_calibrate_normalize_unit.sv =====
// Joystick axis calibration and normalization.
//
// req_* carries one transaction per command: a normal axis event, a calibration
// sample, begin/finish calibration, or a bound load. rsp_* returns results:
// one per normal axis event (scaled Q1.FRACTION_BITS position plus current
// bounds), or one per axis (up to eight) on finish, with rsp_last on the final.
// Both channels are valid/ready; one transaction is in flight at a time and
// req_ready is high only while the sequencer is idle.
//
// A normal event runs a restoring divider that shares one 18-bit subtractor,
// one quotient bit per cycle; a zero span or a saturating value skips the
// divider. req_ready returns the cycle after the result is taken. Sample,
// begin and load pass through an update state; ignored transactions are
// dropped while the sequencer stays idle. Finish walks the axes in turn, and
// each result it emits waits in the result register until it is taken.
// Reset (synchronous) restores bounds to [-32767, 32767] and clears the
// calibration record. A stalled rsp_ready holds the result register and the
// sequencer; no new transaction is taken until the last result is accepted.
`include "axis_range_calibrate_normalize_unit_assert.svh"

module axis_range_calibrate_normalize_unit
   import arcn_pkg::*;
#(
   parameter int NUM_AXES      = NUM_AXES_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_event_type,
   input  logic [7:0]  req_axis_number,
   input  logic signed [15:0] req_sample_value,
   input  logic signed [15:0] req_load_low,
   input  logic signed [15:0] req_load_high,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_axis_index,
   output logic signed [15:0] rsp_scaled_value,
   output logic signed [15:0] rsp_bound_low,
   output logic signed [15:0] rsp_bound_high,
   output logic        rsp_inverted,
   output logic        rsp_last
);

   localparam int AXW   = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
   localparam int QW    = FRACTION_BITS + 1;
   localparam int CNTW  = $clog2(FRACTION_BITS);
   localparam int NOUT  = (NUM_AXES < RESULT_CAP) ? NUM_AXES : RESULT_CAP;
   localparam int REM_W = 17;
   localparam int DIV_W = 16;

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_UPDATE = 3'd1;
   localparam logic [2:0] S_PREP   = 3'd2;
   localparam logic [2:0] S_CMP    = 3'd3;
   localparam logic [2:0] S_DIV    = 3'd4;
   localparam logic [2:0] S_SOUT   = 3'd5;
   localparam logic [2:0] S_FIN    = 3'd6;
   localparam logic [2:0] S_WAIT   = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic [2:0]       cmd_ff, cmd_in;
   logic [AXW-1:0]   axis_ff, axis_in;
   raw_type          sample_ff, sample_in;
   raw_type          load_lo_ff, load_lo_in;
   raw_type          load_hi_ff, load_hi_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] div_ff, div_in;
   logic [QW-1:0]    q_ff, q_in;
   logic             neg_ff, neg_in;
   logic [CNTW-1:0]  cnt_ff, cnt_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_axis_ff, rsp_axis_in;
   raw_type          rsp_scaled_ff, rsp_scaled_in;
   raw_type          rsp_lo_ff, rsp_lo_in;
   raw_type          rsp_hi_ff, rsp_hi_in;
   logic             rsp_inv_ff, rsp_inv_in;
   logic             rsp_last_ff, rsp_last_in;

   store_wr_type     st_wr;
   axis_rec_type     rd;
   logic [1:0]       alu_op;
   raw_type          fin_mn, fin_mx;
   alu_res_type      alu_res;

   logic             axis_ok;
   logic             is_axis;
   logic signed [16:0] span_w;
   alu_word_type     num_w;
   logic signed [16:0] span_neg;
   alu_word_type     num_neg;
   logic signed [31:0] q_s;
   logic signed [31:0] q_signed;
   logic             fin_empty;
   raw_type          new_lo, new_hi;
   logic             fin_emit;
   logic             axis_at_end;

   arcn_axis_store #(
      .NUM_AXES (NUM_AXES),
      .AXW      (AXW)
   ) u_store (
      .clock (clock),
      .reset (reset),
      .idx   (axis_ff),
      .wr    (st_wr),
      .rd    (rd)
   );

   arcn_alu u_alu (
      .op   (alu_op),
      .rem  (alu_word_type'(rem_ff)),
      .div  (alu_word_type'(div_ff)),
      .mn   (fin_mn),
      .mx   (fin_mx),
      .rest (rd.latest),
      .res  (alu_res)
   );

   assign axis_ok = req_axis_number < 8'(NUM_AXES);
   assign is_axis = req_event_type[AXIS_EVENT_BIT];

   // scale setup: span = high - low, numerator = 2*raw - low - high
   assign span_w   = {rd.hi[RAW_W-1], rd.hi} - {rd.lo[RAW_W-1], rd.lo};
   assign num_w    = {sample_ff[RAW_W-1], sample_ff, 1'b0} - sx_raw(rd.lo) - sx_raw(rd.hi);
   assign span_neg = -span_w;
   assign num_neg  = -num_w;

   // signed quotient, truncated to the port width
   assign q_s      = $signed(32'(q_ff));
   assign q_signed = neg_ff ? -q_s : q_s;

   // finish: default an empty range, then orient so rest maps to -1
   assign fin_empty   = $signed(rd.seen_max) <= $signed(rd.seen_min);
   assign fin_mn      = fin_empty ? RAW_NEG : rd.seen_min;
   assign fin_mx      = fin_empty ? RAW_POS : rd.seen_max;
   assign new_lo      = alu_res.ge ? fin_mn : fin_mx;
   assign new_hi      = alu_res.ge ? fin_mx : fin_mn;
   assign fin_emit    = int'(axis_ff) < NOUT;
   assign axis_at_end = axis_ff == AXW'(NUM_AXES - 1);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      axis_in       = axis_ff;
      sample_in     = sample_ff;
      load_lo_in    = load_lo_ff;
      load_hi_in    = load_hi_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      q_in          = q_ff;
      neg_in        = neg_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_axis_in   = rsp_axis_ff;
      rsp_scaled_in = rsp_scaled_ff;
      rsp_lo_in     = rsp_lo_ff;
      rsp_hi_in     = rsp_hi_ff;
      rsp_inv_in    = rsp_inv_ff;
      rsp_last_in   = rsp_last_ff;
      st_wr.op      = ST_NONE;
      st_wr.lo      = load_lo_ff;
      st_wr.hi      = load_hi_ff;
      st_wr.sample  = sample_ff;
      alu_op        = ALU_CMP;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in     = req_command;
               axis_in    = AXW'(req_axis_number);
               sample_in  = req_sample_value;
               load_lo_in = req_load_low;
               load_hi_in = req_load_high;
               unique case (req_command)
                  CMD_EVENT: if (is_axis && axis_ok) state_in = S_PREP;
                  CMD_SAMPLE: if (is_axis && axis_ok) state_in = S_UPDATE;
                  CMD_BEGIN: state_in = S_UPDATE;
                  CMD_FINISH: begin
                     axis_in  = '0;
                     state_in = S_FIN;
                  end
                  CMD_LOAD: if (axis_ok) state_in = S_UPDATE;
                  default: ;
               endcase
            end
         end
         S_UPDATE: begin
            unique case (cmd_ff)
               CMD_SAMPLE: st_wr.op = ST_SAMPLE;
               CMD_BEGIN: st_wr.op = ST_CLEAR;
               CMD_LOAD: st_wr.op = ST_BOUNDS;
               default: st_wr.op = ST_NONE;
            endcase
            state_in = S_IDLE;
         end
         S_PREP: begin
            div_in = span_w[16] ? span_neg[DIV_W-1:0] : span_w[DIV_W-1:0];
            rem_in = num_w[ALU_W-1] ? num_neg[REM_W-1:0] : num_w[REM_W-1:0];
            neg_in = num_w[ALU_W-1] ^ span_w[16];
            if (span_w == '0) begin
               q_in     = '0;
               neg_in   = 1'b0;
               state_in = S_SOUT;
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            // |num| >= |span| saturates at full scale
            alu_op = ALU_CMP;
            if (alu_res.ge) begin
               q_in     = QW'(1) << FRACTION_BITS;
               state_in = S_SOUT;
            end else begin
               q_in     = '0;
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            alu_op = ALU_STEP;
            rem_in = alu_res.ge ? alu_res.diff[REM_W-1:0] : {rem_ff[REM_W-2:0], 1'b0};
            q_in   = {q_ff[QW-2:0], alu_res.ge};
            cnt_in = cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(FRACTION_BITS - 1)) state_in = S_SOUT;
         end
         S_SOUT: begin
            rsp_valid_in  = 1'b1;
            rsp_axis_in   = 3'(axis_ff);
            rsp_scaled_in = q_signed[RAW_W-1:0];
            rsp_lo_in     = rd.lo;
            rsp_hi_in     = rd.hi;
            rsp_inv_in    = $signed(rd.lo) > $signed(rd.hi);
            rsp_last_in   = 1'b1;
            state_in      = S_WAIT;
         end
         S_FIN: begin
            alu_op   = ALU_REST;
            st_wr.op = ST_BOUNDS;
            st_wr.lo = new_lo;
            st_wr.hi = new_hi;
            if (fin_emit) begin
               rsp_valid_in  = 1'b1;
               rsp_axis_in   = 3'(axis_ff);
               rsp_scaled_in = '0;
               rsp_lo_in     = new_lo;
               rsp_hi_in     = new_hi;
               rsp_inv_in    = $signed(new_lo) > $signed(new_hi);
               rsp_last_in   = axis_ff == AXW'(NOUT - 1);
               state_in      = S_WAIT;
            end else if (axis_at_end) begin
               state_in = S_IDLE;
            end else begin
               axis_in = axis_ff + AXW'(1);
            end
         end
         S_WAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (cmd_ff == CMD_FINISH && !axis_at_end) begin
                  axis_in  = axis_ff + AXW'(1);
                  state_in = S_FIN;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      axis_ff       <= axis_in;
      sample_ff     <= sample_in;
      load_lo_ff    <= load_lo_in;
      load_hi_ff    <= load_hi_in;
      rem_ff        <= rem_in;
      div_ff        <= div_in;
      q_ff          <= q_in;
      neg_ff        <= neg_in;
      cnt_ff        <= cnt_in;
      rsp_axis_ff   <= rsp_axis_in;
      rsp_scaled_ff <= rsp_scaled_in;
      rsp_lo_ff     <= rsp_lo_in;
      rsp_hi_ff     <= rsp_hi_in;
      rsp_inv_ff    <= rsp_inv_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_ready        = state_ff == S_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_axis_index   = rsp_axis_ff;
   assign rsp_scaled_value = rsp_scaled_ff;
   assign rsp_bound_low    = rsp_lo_ff;
   assign rsp_bound_high   = rsp_hi_ff;
   assign rsp_inverted     = rsp_inv_ff;
   assign rsp_last         = rsp_last_ff;

   `ARCN_ASSERT_IMP(a_ready_excl, clock, reset, req_ready, !rsp_valid, "ready with a result pending")
   `ARCN_ASSERT_IMP(a_div_rem, clock, reset, state_ff == S_DIV, rem_ff < REM_W'(div_ff), "divider remainder not below divisor")
   `ARCN_ASSERT_IMP(a_fin_last, clock, reset, rsp_valid && cmd_ff == CMD_FINISH, rsp_last == (axis_ff == AXW'(NOUT - 1)), "finish last flag on wrong axis")
   `ARCN_ASSERT_NEXT(a_event_start, clock, reset, req_valid && req_ready && req_command == CMD_EVENT && is_axis && axis_ok, state_ff == S_PREP, "axis event did not start scaling")

endmodule

// ===== tb/sv/axis_range_calibrate_normalize_unit_tb.sv =====
module axis_range_calibrate_normalize_unit_tb
   import arcn_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD  = 12;
   localparam int ITEM_TARGET = 410;
   // generous ceiling, many times the slowest legal run
   localparam int RUN_LIMIT_NS = 10_000_000;
   // margin after the last awaited result to cover any trailing work
   localparam int DRAIN_CYCLES = 64;

   // command codes the block decodes as no-ops
   localparam logic [2:0] CMD_RESERVED_FIRST = 3'd5;
   localparam logic [2:0] CMD_RESERVED_LAST  = 3'd7;

   localparam logic [7:0] AXIS_FLAG = 8'(1 << AXIS_EVENT_BIT);

   typedef struct packed {
      logic [2:0]         command;
      logic [7:0]         event_type;
      logic [7:0]         axis_number;
      logic signed [15:0] sample_value;
      logic signed [15:0] load_low;
      logic signed [15:0] load_high;
   } axis_request_type;

   typedef struct packed {
      logic [2:0]         axis_index;
      logic signed [15:0] scaled_value;
      logic signed [15:0] bound_low;
      logic signed [15:0] bound_high;
      logic               inverted;
      logic               last;
   } axis_result_type;

   typedef enum {RDY_ALWAYS, RDY_COIN, RDY_PATTERN, RDY_SPARSE} ready_mode_type;

   // Mirror of the calibration/normalization behavior. take_command() is fed
   // every accepted request transaction and queues what the block owes;
   // check_output() pops the oldest owed result and compares it.
   class calib_mirror;
      logic signed [15:0] low_b    [NUM_AXES_DEF];
      logic signed [15:0] high_b   [NUM_AXES_DEF];
      logic signed [15:0] seen_min [NUM_AXES_DEF];
      logic signed [15:0] seen_max [NUM_AXES_DEF];
      logic signed [15:0] rest_raw [NUM_AXES_DEF];
      axis_result_type    awaited_results[$];
      int error_count, n_checked, n_effective, n_ignored;
      int n_events, n_samples, n_begins, n_finishes, n_loads;

      function new();
         foreach (low_b[i]) begin
            low_b[i]  = RAW_NEG;
            high_b[i] = RAW_POS;
         end
         forget_seen();
      endfunction

      function void forget_seen();
         foreach (seen_min[i]) begin
            seen_min[i] = RAW_POS;
            seen_max[i] = RAW_NEG;
            rest_raw[i] = '0;
         end
      endfunction

      function int gap_between(int a, int b);
         return (a > b) ? a - b : b - a;
      endfunction

      // (2*d - span) * 2^F / span, truncated toward zero, clamped to +-1; 0 when span is 0
      function logic signed [15:0] normalized(int unsigned a, logic signed [15:0] raw);
         longint one, span, d, q;
         one  = longint'(1) << FRACTION_BITS_DEF;
         span = longint'(high_b[a]) - longint'(low_b[a]);
         if (span == 0)
            return '0;
         d = longint'(raw) - longint'(low_b[a]);
         q = ((2 * d - span) * one) / span;
         if (q < -one) q = -one;
         if (q > one)  q = one;
         return 16'(q);
      endfunction

      function axis_result_type make_result(int unsigned a, logic signed [15:0] scaled,
                                            logic is_last);
         axis_result_type r;
         r.axis_index   = 3'(a);
         r.scaled_value = scaled;
         r.bound_low    = low_b[a];
         r.bound_high   = high_b[a];
         r.inverted     = (low_b[a] > high_b[a]);
         r.last         = is_last;
         return r;
      endfunction

      function void take_command(axis_request_type t);
         logic               is_axis;
         logic               in_range;
         int unsigned        a;
         int unsigned        n_out;
         logic signed [15:0] mn, mx, rest;
         is_axis  = t.event_type[AXIS_EVENT_BIT];
         in_range = (t.axis_number < NUM_AXES_DEF);
         a        = t.axis_number;
         case (t.command)
            CMD_EVENT: begin
               if (!is_axis || !in_range) begin
                  n_ignored++;
                  return;
               end
               awaited_results.push_back(make_result(a, normalized(a, t.sample_value), 1'b1));
               n_events++;
            end
            CMD_SAMPLE: begin
               if (!is_axis || !in_range) begin
                  n_ignored++;
                  return;
               end
               rest_raw[a] = t.sample_value;
               if (t.sample_value < seen_min[a]) seen_min[a] = t.sample_value;
               if (t.sample_value > seen_max[a]) seen_max[a] = t.sample_value;
               n_samples++;
            end
            CMD_BEGIN: begin
               forget_seen();
               n_begins++;
            end
            CMD_FINISH: begin
               n_out = (NUM_AXES_DEF < RESULT_CAP) ? NUM_AXES_DEF : RESULT_CAP;
               for (int unsigned i = 0; i < NUM_AXES_DEF; i++) begin
                  mn   = seen_min[i];
                  mx   = seen_max[i];
                  rest = rest_raw[i];
                  // nothing usable recorded: fall back to the full range
                  if (mx <= mn) begin
                     mn = RAW_NEG;
                     mx = RAW_POS;
                  end
                  // rest value ends up at the -1 end; a tie keeps min as low
                  if (gap_between(rest, mn) <= gap_between(rest, mx)) begin
                     low_b[i]  = mn;
                     high_b[i] = mx;
                  end else begin
                     low_b[i]  = mx;
                     high_b[i] = mn;
                  end
                  if (i < n_out)
                     awaited_results.push_back(make_result(i, '0, i + 1 == n_out));
               end
               n_finishes++;
            end
            CMD_LOAD: begin
               if (!in_range) begin
                  n_ignored++;
                  return;
               end
               low_b[a]  = t.load_low;
               high_b[a] = t.load_high;
               n_loads++;
            end
            default: begin
               n_ignored++;
               return;
            end
         endcase
         n_effective++;
      endfunction

      task report_mismatch(string msg);
         $display("%0t ns mismatch: %s", $realtime, msg);
         error_count++;
      endtask

      task check_output(axis_result_type got);
         axis_result_type want;
         if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result for axis %0d", got.axis_index));
            return;
         end
         want = awaited_results.pop_front();
         n_checked++;
         if (got.axis_index !== want.axis_index)
            report_mismatch($sformatf("axis_index: want %0d got %0d",
                                      want.axis_index, got.axis_index));
         if (got.scaled_value !== want.scaled_value)
            report_mismatch($sformatf("axis %0d scaled_value: want %0d got %0d",
                                      want.axis_index, want.scaled_value, got.scaled_value));
         if (got.bound_low !== want.bound_low)
            report_mismatch($sformatf("axis %0d bound_low: want %0d got %0d",
                                      want.axis_index, want.bound_low, got.bound_low));
         if (got.bound_high !== want.bound_high)
            report_mismatch($sformatf("axis %0d bound_high: want %0d got %0d",
                                      want.axis_index, want.bound_high, got.bound_high));
         if (got.inverted !== want.inverted)
            report_mismatch($sformatf("axis %0d inverted: want %0b got %0b",
                                      want.axis_index, want.inverted, got.inverted));
         if (got.last !== want.last)
            report_mismatch($sformatf("axis %0d last: want %0b got %0b",
                                      want.axis_index, want.last, got.last));
      endtask
   endclass

   // ------------------------------------------------------------------------
   // clock, reset and block inputs; everything starts at a known value
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid        = 1'b0;
   logic               req_ready;
   logic [2:0]         req_command      = '0;
   logic [7:0]         req_event_type   = '0;
   logic [7:0]         req_axis_number  = '0;
   logic signed [15:0] req_sample_value = '0;
   logic signed [15:0] req_load_low     = '0;
   logic signed [15:0] req_load_high    = '0;

   logic               rsp_valid;
   logic               rsp_ready        = 1'b0;
   logic [2:0]         rsp_axis_index;
   logic signed [15:0] rsp_scaled_value;
   logic signed [15:0] rsp_bound_low;
   logic signed [15:0] rsp_bound_high;
   logic               rsp_inverted;
   logic               rsp_last;

   calib_mirror mirror = new();

   always #(CLK_PERIOD / 2) clock = ~clock;

   axis_range_calibrate_normalize_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_event_type   (req_event_type),
      .req_axis_number  (req_axis_number),
      .req_sample_value (req_sample_value),
      .req_load_low     (req_load_low),
      .req_load_high    (req_load_high),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_axis_index   (rsp_axis_index),
      .rsp_scaled_value (rsp_scaled_value),
      .rsp_bound_low    (rsp_bound_low),
      .rsp_bound_high   (rsp_bound_high),
      .rsp_inverted     (rsp_inverted),
      .rsp_last         (rsp_last)
   );

   // ------------------------------------------------------------------------
   // Response side. Outputs are sampled right at the rising edge, so the
   // values seen are the ones the block presented during the cycle that just
   // closed. rsp_ready follows a mode that is redrawn whenever its random age
   // runs out: always ready (no-stall stretches), coin flip, a rotating 32-bit
   // pattern, or mostly stalled.
   // ------------------------------------------------------------------------
   ready_mode_type ready_mode = RDY_ALWAYS;
   logic [31:0]    ready_bits = '1;
   int             ready_age  = 0;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         mirror.check_output('{rsp_axis_index, rsp_scaled_value, rsp_bound_low,
                               rsp_bound_high, rsp_inverted, rsp_last});
      if (ready_age == 0) begin
         ready_age  = $urandom_range(16, 80);
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         ready_bits = $urandom;
      end
      ready_age--;
      case (ready_mode)
         RDY_ALWAYS:  rsp_ready <= 1'b1;
         RDY_COIN:    rsp_ready <= 1'($urandom_range(0, 1));
         RDY_PATTERN: begin
            rsp_ready <= ready_bits[0];
            ready_bits = {ready_bits[0], ready_bits[31:1]};
         end
         default:     rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // ------------------------------------------------------------------------
   // Request side. One transaction per call; valid stays up across a burst
   // and drops for a random gap between bursts. Bursts are occasionally long
   // so back-to-back traffic is exercised too.
   // ------------------------------------------------------------------------
   int burst_left = 0;

   task automatic send(input logic [2:0] cmd, input logic [7:0] etype,
                       input logic [7:0] axis, input logic signed [15:0] sample,
                       input logic signed [15:0] lo, input logic signed [15:0] hi);
      axis_request_type t;
      t = '{cmd, etype, axis, sample, lo, hi};
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_event_type   <= etype;
      req_axis_number  <= axis;
      req_sample_value <= sample;
      req_load_low     <= lo;
      req_load_high    <= hi;
      do @(posedge clock); while (!req_ready);
      mirror.take_command(t);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end else begin
         burst_left--;
      end
   endtask

   function automatic logic signed [15:0] rand16();
      return 16'($urandom);
   endfunction

   // random event type that always carries the axis flag
   function automatic logic [7:0] axis_flags();
      return 8'($urandom) | AXIS_FLAG;
   endfunction

   // raw positions with the range ends showing up often
   function automatic logic signed [15:0] any_raw();
      case ($urandom_range(0, 7))
         0:       return -16'sd32768;
         1:       return RAW_NEG;
         2:       return RAW_POS;
         3:       return 16'($urandom_range(0, 64)) - 16'sd32;
         default: return rand16();
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      int                 pick;
      int                 lo_i, hi_i;
      logic [2:0]         ax;
      logic signed [15:0] lo, hi;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      // reset bounds: both ends of the raw range, full event-type byte
      send(CMD_EVENT, AXIS_FLAG, 8'd0, 16'sd32767, rand16(), rand16());
      send(CMD_EVENT, 8'hFF, 8'd7, -16'sd32768, rand16(), rand16());
      // not an axis event, and axes past the end: all dropped
      send(CMD_EVENT, 8'hFD, 8'd1, 16'sd100, rand16(), rand16());
      send(CMD_EVENT, AXIS_FLAG, 8'd8, 16'sd100, rand16(), rand16());
      send(CMD_EVENT, AXIS_FLAG, 8'd255, 16'sd100, rand16(), rand16());
      // inverted bounds via load, then a midpoint event
      send(CMD_LOAD, 8'h00, 8'd2, rand16(), 16'sd100, -16'sd100);
      send(CMD_EVENT, AXIS_FLAG, 8'd2, 16'sd0, rand16(), rand16());
      // zero span reads as 0
      send(CMD_LOAD, 8'h00, 8'd4, rand16(), 16'sd500, 16'sd500);
      send(CMD_EVENT, AXIS_FLAG, 8'd4, 16'sd1234, rand16(), rand16());
      // load to a nonexistent axis is dropped
      send(CMD_LOAD, 8'h00, 8'hF0, rand16(), 16'sd1, 16'sd2);
      // widest possible span, value at the low end
      send(CMD_LOAD, 8'h00, 8'd5, rand16(), -16'sd32768, 16'sd32767);
      send(CMD_EVENT, AXIS_FLAG, 8'd5, -16'sd32768, rand16(), rand16());
      // spare command codes
      for (int c = CMD_RESERVED_FIRST; c <= CMD_RESERVED_LAST; c++)
         send(3'(c), 8'($urandom), 8'($urandom_range(0, 7)), rand16(), rand16(), rand16());
      // calibration: a dropped sample, a rest tie on axis 0, a rest near the
      // max on axis 6, a single-value (empty) range on axis 3, and untouched
      // axes falling back to the full range
      send(CMD_BEGIN, 8'h00, 8'h00, rand16(), rand16(), rand16());
      send(CMD_SAMPLE, 8'hFD, 8'd1, -16'sd5000, rand16(), rand16());
      send(CMD_SAMPLE, AXIS_FLAG, 8'd0, -16'sd1000, rand16(), rand16());
      send(CMD_SAMPLE, AXIS_FLAG, 8'd0, 16'sd3000, rand16(), rand16());
      send(CMD_SAMPLE, AXIS_FLAG, 8'd0, 16'sd1000, rand16(), rand16());
      send(CMD_SAMPLE, AXIS_FLAG, 8'd6, 16'sd200, rand16(), rand16());
      send(CMD_SAMPLE, AXIS_FLAG, 8'd6, 16'sd9000, rand16(), rand16());
      send(CMD_SAMPLE, AXIS_FLAG, 8'd6, 16'sd8800, rand16(), rand16());
      send(CMD_SAMPLE, AXIS_FLAG, 8'd3, 16'sd500, rand16(), rand16());
      send(CMD_FINISH, 8'h00, 8'h00, rand16(), rand16(), rand16());
      send(CMD_EVENT, AXIS_FLAG, 8'd6, 16'sd9000, rand16(), rand16());

      // --- random: mostly well-formed flows, some noise ---
      while (mirror.n_effective + mirror.n_ignored < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            repeat ($urandom_range(1, 6))
               send(CMD_EVENT, axis_flags(), 8'($urandom_range(0, 7)), any_raw(),
                    rand16(), rand16());
         end else if (pick < 55) begin
            send(CMD_BEGIN, 8'($urandom), 8'($urandom), rand16(), rand16(), rand16());
            repeat ($urandom_range(2, 14))
               send(CMD_SAMPLE, axis_flags(), 8'($urandom_range(0, 7)), any_raw(),
                    rand16(), rand16());
            // sometimes land the rest value exactly midway on one axis
            if ($urandom_range(0, 3) == 0) begin
               ax   = 3'($urandom_range(0, 7));
               lo_i = int'($urandom_range(0, 30000)) - 30000;
               hi_i = lo_i + 2 * int'($urandom_range(1, 15000));
               send(CMD_SAMPLE, axis_flags(), 8'(ax), 16'(lo_i), rand16(), rand16());
               send(CMD_SAMPLE, axis_flags(), 8'(ax), 16'(hi_i), rand16(), rand16());
               send(CMD_SAMPLE, axis_flags(), 8'(ax), 16'((lo_i + hi_i) / 2),
                    rand16(), rand16());
            end
            send(CMD_FINISH, 8'($urandom), 8'($urandom), rand16(), rand16(), rand16());
            repeat ($urandom_range(0, 4))
               send(CMD_EVENT, axis_flags(), 8'($urandom_range(0, 7)), any_raw(),
                    rand16(), rand16());
         end else if (pick < 70) begin
            ax = 3'($urandom_range(0, 7));
            lo = any_raw();
            case ($urandom_range(0, 5))
               0:       hi = lo;
               1:       hi = lo + 16'($urandom_range(1, 8));
               default: hi = any_raw();
            endcase
            send(CMD_LOAD, 8'($urandom), 8'(ax), rand16(), lo, hi);
            repeat ($urandom_range(1, 4))
               send(CMD_EVENT, axis_flags(), 8'(ax), any_raw(), rand16(), rand16());
         end else if (pick < 82) begin
            // finish on whatever the record holds now
            send(CMD_FINISH, 8'($urandom), 8'($urandom), rand16(), rand16(), rand16());
         end else begin
            send(3'($urandom), 8'($urandom), 8'($urandom), rand16(), rand16(), rand16());
         end
      end

      // --- drain ---
      req_valid <= 1'b0;
      while (mirror.awaited_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d events, %0d samples, %0d begins, %0d finishes, %0d loads",
               mirror.n_events, mirror.n_samples, mirror.n_begins, mirror.n_finishes,
               mirror.n_loads);
      $display("plus %0d dropped transactions; %0d results compared, %0d mismatches",
               mirror.n_ignored, mirror.n_checked, mirror.error_count);
      if (mirror.error_count == 0)
         $display("[axis_range_calibrate_normalize_unit] OK");
      else
         $display("[axis_range_calibrate_normalize_unit] ERROR");
      $finish;
   end

   // hard stop if the block hangs
   initial begin
      #(RUN_LIMIT_NS);
      $display("timeout with %0d results outstanding", mirror.awaited_results.size());
      $display("[axis_range_calibrate_normalize_unit] ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/arcn_pkg.sv
hdl/arcn_axis_store.sv
hdl/arcn_alu.sv
hdl/axis_range_calibrate_normalize_unit.sv
tb/sv/axis_range_calibrate_normalize_unit_tb.sv
